// ===== rtl/pfr_pkg.sv =====
// Shared types, constants and the dominance compare of the Pareto front ranker.
package pfr_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned ObjW      = 32;
  localparam int unsigned InW       = 32;
  localparam int unsigned OutW      = 6;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned LdW       = $clog2(MaxPoints + 1);

  typedef struct packed {
    logic [ObjW-1:0] pwr;
    logic [ObjW-1:0] tim;
  } point_t;

  typedef enum logic [1:0] {
    MODE_COUNT   = 2'd0,
    MODE_MARK    = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef struct packed {
    logic  load_en;
    logic  clr_set;
    logic  i_clr;
    logic  i_inc;
    logic  piv_lat;
    logic  scan_start;
    logic  scan_run;
    mode_e mode;
    logic  cnt_wr;
    logic  rank_init;
    logic  front_clr;
    logic  front_inc;
    logic  out_ld;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic i_last;
    logic i_in_front;
    logic all_done;
    logic out_taken;
  } status_t;

  // True when point a dominates point b.
  function automatic logic beats(point_t a, point_t b);
    logic no_worse;
    logic better;
    no_worse = (a.pwr <= b.pwr) && (a.tim <= b.tim);
    better   = (a.pwr < b.pwr) || (a.tim < b.tim);
    return no_worse && better;
  endfunction

endpackage

// ===== rtl/pfr_dp.sv =====
// Datapath of the Pareto front ranker: point, count and rank memories, scan and output registers.
module pfr_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pfr_pkg::cmd_t             cmd_i,
  output pfr_pkg::status_t          status_o,
  input  logic [pfr_pkg::InW-1:0]   power_value_i,
  input  logic [pfr_pkg::InW-1:0]   time_value_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [pfr_pkg::OutW-1:0]  point_index_o,
  output logic [pfr_pkg::OutW-1:0]  front_rank_o,
  output logic                      last_result_o,
  output logic                      points_dropped_o
);

  pfr_pkg::point_t obj_mem [pfr_pkg::MaxPoints];
  pfr_pkg::point_t obj_rd_q;
  pfr_pkg::point_t pivot_q;
  pfr_pkg::point_t in_point;

  logic [pfr_pkg::IdxW-1:0] cnt_mem  [pfr_pkg::MaxPoints];
  logic [pfr_pkg::IdxW-1:0] rank_mem [pfr_pkg::MaxPoints];
  logic [pfr_pkg::IdxW-1:0] cnt_rd_q;
  logic [pfr_pkg::IdxW-1:0] rank_rd_q;

  logic [pfr_pkg::LdW-1:0]  loaded_q;
  logic                     ovf_q;
  logic [pfr_pkg::IdxW-1:0] i_q;
  logic [pfr_pkg::LdW-1:0]  j_q;
  logic                     s_vld_q;
  logic [pfr_pkg::IdxW-1:0] s_idx_q;
  logic [pfr_pkg::IdxW-1:0] acc_q;
  logic [pfr_pkg::MaxPoints-1:0] ranked_q;
  logic [pfr_pkg::MaxPoints-1:0] front_q;
  logic [pfr_pkg::IdxW-1:0] front_num_q;
  logic [pfr_pkg::LdW-1:0]  done_q;

  logic                     out_valid_q;
  logic [pfr_pkg::OutW-1:0] out_idx_q;
  logic [pfr_pkg::OutW-1:0] out_rank_q;
  logic                     out_last_q;
  logic                     out_drop_q;

  logic                     has_room;
  logic                     obj_we;
  logic                     issue;
  logic [pfr_pkg::IdxW-1:0] rd_addr;
  logic                     cnt_hit;
  logic                     mark_hit;
  logic                     rel_dec;
  logic                     cnt_we;
  logic [pfr_pkg::IdxW-1:0] cnt_waddr;
  logic [pfr_pkg::IdxW-1:0] cnt_wdata;
  logic                     i_last;

  assign in_point.pwr = pfr_pkg::ObjW'(power_value_i);
  assign in_point.tim = pfr_pkg::ObjW'(time_value_i);

  assign has_room = loaded_q < pfr_pkg::LdW'(pfr_pkg::MaxPoints);
  assign obj_we   = cmd_i.load_en && has_room;
  assign issue    = cmd_i.scan_run && (j_q < loaded_q);
  assign rd_addr  = cmd_i.scan_run ? j_q[pfr_pkg::IdxW-1:0] : i_q;

  assign cnt_hit  = s_vld_q && (cmd_i.mode == pfr_pkg::MODE_COUNT) &&
                    pfr_pkg::beats(obj_rd_q, pivot_q);
  assign mark_hit = s_vld_q && (cmd_i.mode == pfr_pkg::MODE_MARK) &&
                    !ranked_q[s_idx_q] && (cnt_rd_q == '0);
  assign rel_dec  = s_vld_q && (cmd_i.mode == pfr_pkg::MODE_RELEASE) &&
                    !ranked_q[s_idx_q] && (cnt_rd_q != '0) &&
                    pfr_pkg::beats(pivot_q, obj_rd_q);

  assign cnt_we    = cmd_i.cnt_wr || rel_dec;
  assign cnt_waddr = cmd_i.cnt_wr ? i_q : s_idx_q;
  assign cnt_wdata = cmd_i.cnt_wr ? acc_q : cnt_rd_q - pfr_pkg::IdxW'(1);

  assign i_last = (pfr_pkg::LdW'(i_q) + pfr_pkg::LdW'(1)) == loaded_q;

  always_ff @(posedge clk_i) begin
    if (obj_we) begin
      obj_mem[loaded_q[pfr_pkg::IdxW-1:0]] <= in_point;
    end
    obj_rd_q <= obj_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_hit) begin
      rank_mem[s_idx_q] <= front_num_q;
    end
    rank_rd_q <= rank_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.piv_lat) begin
      pivot_q <= obj_rd_q;
    end
    if (cmd_i.out_ld) begin
      out_idx_q  <= pfr_pkg::OutW'(i_q);
      out_rank_q <= pfr_pkg::OutW'(rank_rd_q);
      out_last_q <= i_last;
      out_drop_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      s_vld_q     <= 1'b0;
      s_idx_q     <= '0;
      acc_q       <= '0;
      ranked_q    <= '0;
      front_q     <= '0;
      front_num_q <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_set) begin
        loaded_q <= '0;
        ovf_q    <= 1'b0;
      end else if (cmd_i.load_en) begin
        if (has_room) begin
          loaded_q <= loaded_q + pfr_pkg::LdW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + pfr_pkg::IdxW'(1);
      end

      if (cmd_i.scan_start) begin
        j_q <= '0;
      end else if (issue) begin
        j_q <= j_q + pfr_pkg::LdW'(1);
      end
      s_vld_q <= issue;
      s_idx_q <= j_q[pfr_pkg::IdxW-1:0];

      if (cmd_i.scan_start) begin
        acc_q <= '0;
      end else if (cnt_hit) begin
        acc_q <= acc_q + pfr_pkg::IdxW'(1);
      end

      if (cmd_i.rank_init) begin
        ranked_q <= '0;
      end else if (mark_hit) begin
        ranked_q[s_idx_q] <= 1'b1;
      end

      if (cmd_i.front_clr) begin
        front_q <= '0;
      end else if (mark_hit) begin
        front_q[s_idx_q] <= 1'b1;
      end

      if (cmd_i.rank_init) begin
        front_num_q <= '0;
      end else if (cmd_i.front_inc) begin
        front_num_q <= front_num_q + pfr_pkg::IdxW'(1);
      end

      if (cmd_i.rank_init || cmd_i.clr_set) begin
        done_q <= '0;
      end else if (mark_hit) begin
        done_q <= done_q + pfr_pkg::LdW'(1);
      end

      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.scan_done  = cmd_i.scan_run && !issue && !s_vld_q;
  assign status_o.i_last     = i_last;
  assign status_o.i_in_front = front_q[i_q];
  assign status_o.all_done   = done_q == loaded_q;
  assign status_o.out_taken  = out_valid_q && out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign point_index_o    = out_idx_q;
  assign front_rank_o     = out_rank_q;
  assign last_result_o    = out_last_q;
  assign points_dropped_o = out_drop_q;

  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= loaded_q)
    else $error("More points ranked than loaded.");

  a_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> !out_valid_q)
    else $error("Result loaded over a pending beat.");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q |-> (pfr_pkg::LdW'(s_idx_q) < loaded_q))
    else $error("Scan index beyond the stored points.");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_en |-> !s_vld_q)
    else $error("Point loaded during a scan.");

endmodule

// ===== rtl/pfr_ctrl.sv =====
// Controller of the Pareto front ranker: sequences load, counting, front peeling and output.
module pfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_point_i,
  output logic              in_ready_o,
  input  pfr_pkg::status_t  status_i,
  output pfr_pkg::cmd_t     cmd_o
);

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_C_PIV   = 15'b000000000000010,
    ST_C_LAT   = 15'b000000000000100,
    ST_C_SCAN  = 15'b000000000001000,
    ST_C_WR    = 15'b000000000010000,
    ST_M_START = 15'b000000000100000,
    ST_M_SCAN  = 15'b000000001000000,
    ST_R_SEL   = 15'b000000010000000,
    ST_R_LAT   = 15'b000000100000000,
    ST_R_SCAN  = 15'b000001000000000,
    ST_R_NEXT  = 15'b000010000000000,
    ST_R_END   = 15'b000100000000000,
    ST_O_RD    = 15'b001000000000000,
    ST_O_LD    = 15'b010000000000000,
    ST_O_HOLD  = 15'b100000000000000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_en = accept;
        if (accept && last_point_i) begin
          cmd_o.i_clr     = 1'b1;
          cmd_o.rank_init = 1'b1;
          state_d         = ST_C_PIV;
        end
      end
      ST_C_PIV: begin
        state_d = ST_C_LAT;
      end
      ST_C_LAT: begin
        cmd_o.piv_lat    = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_C_SCAN;
      end
      ST_C_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.mode     = pfr_pkg::MODE_COUNT;
        if (status_i.scan_done) begin
          state_d = ST_C_WR;
        end
      end
      ST_C_WR: begin
        cmd_o.cnt_wr = 1'b1;
        if (status_i.i_last) begin
          state_d = ST_M_START;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_C_PIV;
        end
      end
      ST_M_START: begin
        cmd_o.front_clr  = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_M_SCAN;
      end
      ST_M_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.mode     = pfr_pkg::MODE_MARK;
        if (status_i.scan_done) begin
          cmd_o.i_clr = 1'b1;
          state_d     = ST_R_SEL;
        end
      end
      ST_R_SEL: begin
        if (status_i.i_in_front) begin
          state_d = ST_R_LAT;
        end else if (status_i.i_last) begin
          state_d = ST_R_END;
        end else begin
          cmd_o.i_inc = 1'b1;
        end
      end
      ST_R_LAT: begin
        cmd_o.piv_lat    = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_R_SCAN;
      end
      ST_R_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.mode     = pfr_pkg::MODE_RELEASE;
        if (status_i.scan_done) begin
          state_d = ST_R_NEXT;
        end
      end
      ST_R_NEXT: begin
        if (status_i.i_last) begin
          state_d = ST_R_END;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_R_SEL;
        end
      end
      ST_R_END: begin
        if (status_i.all_done) begin
          cmd_o.i_clr = 1'b1;
          state_d     = ST_O_RD;
        end else begin
          cmd_o.front_inc = 1'b1;
          state_d         = ST_M_START;
        end
      end
      ST_O_RD: begin
        state_d = ST_O_LD;
      end
      ST_O_LD: begin
        cmd_o.out_ld = 1'b1;
        state_d      = ST_O_HOLD;
      end
      ST_O_HOLD: begin
        if (status_i.out_taken) begin
          if (status_i.i_last) begin
            cmd_o.clr_set = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            cmd_o.i_inc = 1'b1;
            state_d     = ST_O_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pareto_front_ranking.sv =====
// Top level of the Pareto front ranker: controller and datapath.
//
// The input channel takes one point per beat: two unsigned costs, power and
// time, plus a last flag. Up to 64 points are stored per set; further points
// are discarded and every result of that set then reports points_dropped.
// The beat marked last closes the set and starts ranking; no input beat is
// taken until every result of the set has been delivered.
// The output channel gives one beat per stored point in load order, with its
// index and Pareto front rank; the beat of the final stored point carries
// last_result.
// Loading takes one point per cycle. Ranking first counts the dominators of
// every point, then per front marks it, walks the set to close the front, and
// lets each member release the points it dominates; every scan goes through
// the single read port of the point memory. Output reads, loads and holds
// each result in turn, so a new result is loaded only after the last beat is
// taken; a stall holds the result register and the controller until the beat
// is taken. Reset empties the set and returns to loading; memory contents
// need no clearing.
module pareto_front_ranking (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pfr_pkg::InW-1:0]   power_value_i,
  input  logic [pfr_pkg::InW-1:0]   time_value_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pfr_pkg::OutW-1:0]  point_index_o,
  output logic [pfr_pkg::OutW-1:0]  front_rank_o,
  output logic                      last_result_o,
  output logic                      points_dropped_o
);

  pfr_pkg::cmd_t    cmd;
  pfr_pkg::status_t status;

  pfr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .in_ready_o   (in_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  pfr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .power_value_i    (power_value_i),
    .time_value_i     (time_value_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .point_index_o    (point_index_o),
    .front_rank_o     (front_rank_o),
    .last_result_o    (last_result_o),
    .points_dropped_o (points_dropped_o)
  );

endmodule

// ===== tb/tb_pareto_front_ranking.sv =====
// Self-checking testbench of the Pareto front ranker: bursty point sets, a stalling receiver.
module tb_pareto_front_ranking;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = pfr_pkg::MaxPoints;
  localparam int unsigned VW  = pfr_pkg::InW;
  localparam int unsigned RW  = pfr_pkg::OutW;
  localparam logic [VW-1:0] VMax = '1;

  typedef enum int unsigned {
    SET_TIGHT,
    SET_WIDE,
    SET_EDGE
  } set_style_e;

  typedef enum int unsigned {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  typedef struct {
    logic [VW-1:0] pwr;
    logic [VW-1:0] tim;
    logic          last;
    logic          drain_first;
  } point_beat_t;

  typedef struct {
    logic [RW-1:0] idx;
    logic [RW-1:0] rank;
    logic          last;
    logic          dropped;
  } rank_beat_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [VW-1:0] power_value = '0;
  logic [VW-1:0] time_value = '0;
  logic          last_point = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [RW-1:0] point_index;
  logic [RW-1:0] front_rank;
  logic          last_result;
  logic          points_dropped;

  point_beat_t   pending_points[$];
  rank_beat_t    expected_ranks[$];

  logic [VW-1:0] set_pwr [Cap];
  logic [VW-1:0] set_tim [Cap];
  int unsigned   set_fill = 0;
  logic          set_overflow = 1'b0;

  int unsigned   points_queued = 0;
  int unsigned   points_sent = 0;
  int unsigned   sets_ranked = 0;
  int unsigned   overflow_sets = 0;
  int unsigned   results_checked = 0;
  int unsigned   deepest_front = 0;
  int unsigned   mismatches = 0;

  pareto_front_ranking dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .power_value_i    (power_value),
    .time_value_i     (time_value),
    .last_point_i     (last_point),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .point_index_o    (point_index),
    .front_rank_o     (front_rank),
    .last_result_o    (last_result),
    .points_dropped_o (points_dropped)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit dominates(logic [VW-1:0] ap, logic [VW-1:0] at,
                                   logic [VW-1:0] bp, logic [VW-1:0] bt);
    return (ap <= bp) && (at <= bt) && ((ap < bp) || (at < bt));
  endfunction

  // The front of a point is the length of the longest chain of points above it.
  function automatic void rank_fronts();
    int unsigned depth [Cap];
    bit          grew;
    rank_beat_t  r;
    for (int i = 0; i < set_fill; i++) depth[i] = 0;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int i = 0; i < set_fill; i++) begin
        for (int j = 0; j < set_fill; j++) begin
          if (dominates(set_pwr[j], set_tim[j], set_pwr[i], set_tim[i]) &&
              depth[i] < depth[j] + 1) begin
            depth[i] = depth[j] + 1;
            grew = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < set_fill; i++) begin
      r.idx     = RW'(i);
      r.rank    = RW'(depth[i]);
      r.last    = (i + 1 == set_fill);
      r.dropped = set_overflow;
      expected_ranks = {expected_ranks, r};
      if (depth[i] > deepest_front) deepest_front = depth[i];
    end
    sets_ranked++;
    if (set_overflow) overflow_sets++;
    set_fill = 0;
    set_overflow = 1'b0;
  endfunction

  function automatic void load_point(logic [VW-1:0] p, logic [VW-1:0] t, logic last);
    if (set_fill < Cap) begin
      set_pwr[set_fill] = p;
      set_tim[set_fill] = t;
      set_fill++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last) rank_fronts();
  endfunction

  function automatic void add_point(logic [VW-1:0] p, logic [VW-1:0] t, logic last,
                                    logic hold);
    point_beat_t b;
    b.pwr = p;
    b.tim = t;
    b.last = last;
    b.drain_first = hold;
    pending_points = {pending_points, b};
    points_queued++;
  endfunction

  function automatic logic [VW-1:0] pick_cost(set_style_e style);
    case (style)
      SET_TIGHT: return VW'($urandom_range(0, 7));
      SET_WIDE:  return VW'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return VMax;
          2:       return VW'($urandom_range(0, 3));
          default: return VMax - VW'($urandom_range(0, 3));
        endcase
      end
    endcase
  endfunction

  function automatic void add_random_set(int unsigned n);
    set_style_e style;
    logic       hold;
    style = set_style_e'($urandom_range(0, 2));
    hold = ($urandom_range(0, 2) == 0);
    for (int k = 0; k < n; k++) begin
      add_point(pick_cost(style), pick_cost(style), k == n - 1, hold && k == 0);
    end
  endfunction

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    point_beat_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        load_point(power_value, time_value, last_point);
        points_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_points.size() != 0 &&
                     !(pending_points[0].drain_first && expected_ranks.size() != 0)) begin
          nxt = pending_points.pop_front();
          in_valid <= 1'b1;
          power_value <= nxt.pwr;
          time_value <= nxt.tim;
          last_point <= nxt.last;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 5);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_span = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk_i) begin
    rank_beat_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ranks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result beat: idx %0d rank %0d last %0b drop %0b",
                     point_index, front_rank, last_result, points_dropped);
          end
        end else begin
          want = expected_ranks.pop_front();
          results_checked++;
          if (point_index !== want.idx || front_rank !== want.rank ||
              last_result !== want.last || points_dropped !== want.dropped) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected idx %0d rank %0d last %0b drop %0b,",
                       want.idx, want.rank, want.last, want.dropped);
              $display("  got idx %0d rank %0d last %0b drop %0b",
                       point_index, front_rank, last_result, points_dropped);
            end
          end
        end
      end
      if (rx_span == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_span = $urandom_range(8, 48);
      end
      rx_span--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        default:   out_ready <= (rx_tick % 5 == 0);
      endcase
    end
  end

  initial begin
    int unsigned perm [Cap];
    int unsigned pick;
    int unsigned tmp;
    int unsigned extra;

    add_point('0, '0, 1'b1, 1'b0);
    add_point(VMax, VMax, 1'b1, 1'b0);
    add_point(32'd5, 32'd5, 1'b0, 1'b1);
    add_point(32'd5, 32'd5, 1'b0, 1'b0);
    add_point(32'd3, 32'd7, 1'b0, 1'b0);
    add_point(32'd7, 32'd3, 1'b0, 1'b0);
    add_point(32'd5, 32'd6, 1'b0, 1'b0);
    add_point(32'd6, 32'd6, 1'b0, 1'b0);
    add_point(32'd8, 32'd8, 1'b0, 1'b0);
    add_point('0, VMax, 1'b0, 1'b0);
    add_point(VMax, '0, 1'b1, 1'b0);
    for (int k = 4; k >= 0; k--) add_point(VW'(k), VW'(k), k == 0, 1'b0);
    add_point(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0);
    add_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0);

    for (int s = 0; s < 2; s++) add_random_set($urandom_range(1, 6));
    for (int s = 0; s < 2; s++) add_random_set($urandom_range(1, 6));

    // A shuffled chain fills every front from 0 to 63; the extra beats overflow the set.
    for (int k = 0; k < Cap; k++) perm[k] = k;
    for (int k = Cap - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = perm[k];
      perm[k] = perm[pick];
      perm[pick] = tmp;
    end
    for (int k = 0; k < Cap; k++) begin
      add_point(VW'(perm[k]) * 32'h0400_0001, VW'(perm[k]) * 32'h0300_0000 + 32'd5,
                1'b0, k == 0);
    end
    extra = $urandom_range(1, 3);
    for (int k = 0; k < extra; k++) begin
      add_point(VW'($urandom()), VW'($urandom()), k == extra - 1, 1'b0);
    end

    for (int s = 0; s < 2; s++) add_random_set($urandom_range(1, 6));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (points_sent != points_queued) @(posedge clk_i);
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    mismatches += expected_ranks.size();
    $display("Coverage: %0d point beats in %0d sets (%0d over capacity), deepest front %0d.",
             points_sent, sets_ranked, overflow_sets, deepest_front);
    $display("Checked %0d result beats, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
